>>> rtl/d2h_pkg.sv
// Package with the payload types, control word types and microcode table of the converter.
`timescale 1ns / 1ps

package d2h_pkg;

    // Fixed field widths of the channels.
    localparam int HS_W         = 6;
    localparam int ADDR_FIELD_W = 24;
    localparam int DATA_FIELD_W = 64;
    localparam int OFFSET_W     = 16;

    // Reset value of the hack size register.
    localparam logic [HS_W-1:0] HS_RESET = 6'd32;

    // Result kinds.
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_DIAG  = 2'd1;
    localparam logic [1:0] KIND_HACK  = 2'd2;

    // One input item.
    typedef struct packed {
        logic [63:0]                element_bits;
        logic signed [OFFSET_W-1:0] diag_offset;
        logic                       end_of_diagonal;
        logic                       end_of_hack;
    } in_t;

    // One result item.
    typedef struct packed {
        logic [1:0]              kind;
        logic [ADDR_FIELD_W-1:0] address;
        logic [DATA_FIELD_W-1:0] data;
        logic                    overflow;
        logic                    last;
    } out_t;

    // Microprogram steps.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GROUP,
        ST_DOFF,
        ST_READ,
        ST_VAL,
        ST_GDONE,
        ST_HACK
    } step_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ACC_END,
        C_NZ,
        C_MORE,
        C_EOH
    } cond_t;

    // How the last flag of an emitted result is formed.
    typedef enum logic [1:0] {
        LAST_NONE,
        LAST_ROWS,
        LAST_ALWAYS
    } last_sel_t;

    // Control word fields that drive the datapath.
    typedef struct packed {
        logic      take;
        logic      base_load;
        logic      rd_en;
        logic      emit;
        logic [1:0] kind;
        last_sel_t last_sel;
        logic      group_done;
    } ctrl_t;

    // Status returned by the datapath for jump decisions.
    typedef struct packed {
        logic acc_end;
        logic nz;
        logic more;
        logic eoh;
        logic out_free;
    } stat_t;

    // One full microcode word.
    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t target;
        step_t nxt;
    } ucode_t;

    // Read-only microprogram. A taken condition goes to target, otherwise to nxt.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{ctrl: '{take: 1'b0, base_load: 1'b0, rd_en: 1'b0, emit: 1'b0,
                      kind: KIND_VALUE, last_sel: LAST_NONE, group_done: 1'b0},
              cond: C_NEVER, target: ST_IDLE, nxt: ST_IDLE};
        unique case (step)
            ST_IDLE: begin
                w.ctrl.take = 1'b1;
                w.cond      = C_ACC_END;
                w.target    = ST_GROUP;
                w.nxt       = ST_IDLE;
            end
            ST_GROUP: begin
                w.ctrl.base_load = 1'b1;
                w.cond           = C_NZ;
                w.target         = ST_DOFF;
                w.nxt            = ST_GDONE;
            end
            ST_DOFF: begin
                w.ctrl.emit = 1'b1;
                w.ctrl.kind = KIND_DIAG;
                w.nxt       = ST_READ;
            end
            ST_READ: begin
                w.ctrl.rd_en = 1'b1;
                w.nxt        = ST_VAL;
            end
            ST_VAL: begin
                w.ctrl.emit     = 1'b1;
                w.ctrl.kind     = KIND_VALUE;
                w.ctrl.last_sel = LAST_ROWS;
                w.cond          = C_MORE;
                w.target        = ST_READ;
                w.nxt           = ST_GDONE;
            end
            ST_GDONE: begin
                w.ctrl.group_done = 1'b1;
                w.cond            = C_EOH;
                w.target          = ST_HACK;
                w.nxt             = ST_IDLE;
            end
            ST_HACK: begin
                w.ctrl.emit     = 1'b1;
                w.ctrl.kind     = KIND_HACK;
                w.ctrl.last_sel = LAST_ALWAYS;
                w.nxt           = ST_IDLE;
            end
            default: begin
                w.nxt = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/d2h_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module d2h_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/d2h_seq.sv
// Microcode sequencer: step counter, control word table and conditional jumps.
`timescale 1ns / 1ps

module d2h_seq
    import d2h_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   taken;

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // Fetch the control word, evaluate its condition and pick the next step.
    always_comb begin
        word = ucode_rom(step_reg);
        unique case (word.cond)
            C_ACC_END: taken = stat.acc_end;
            C_NZ:      taken = stat.nz;
            C_MORE:    taken = stat.more;
            C_EOH:     taken = stat.eoh;
            default:   taken = 1'b0;
        endcase
        if (word.ctrl.emit && !stat.out_free) begin
            // The output register is still occupied, so the emitting step waits.
            step_next = step_reg;
        end else if (taken) begin
            step_next = word.target;
        end else begin
            step_next = word.nxt;
        end
        ctrl = word.ctrl;
    end

endmodule

>>> rtl/d2h_dp.sv
// Datapath: group buffer, counters, address arithmetic and the output register.
`timescale 1ns / 1ps

module d2h_dp
    import d2h_pkg::*;
#(
    parameter int HACK_MAX     = 32,
    parameter int ELEMENT_BITS = 64,
    parameter int ADDRESS_BITS = 24
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  ctrl_t           ctrl,
    output stat_t           stat,
    input  logic            cfg_valid,
    input  logic [HS_W-1:0] cfg_data,
    input  logic            s_valid,
    input  in_t             s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_t            m_data
);

    localparam int RW  = $clog2(HACK_MAX + 1);
    localparam int RAW = (HACK_MAX > 1) ? $clog2(HACK_MAX) : 1;
    localparam int BW  = ADDRESS_BITS + HS_W;
    localparam int SW  = BW + 1;
    localparam int AXW = (ADDRESS_BITS > ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;
    localparam logic [ADDRESS_BITS-1:0] ADDR_MAX = '1;

    logic [HS_W-1:0]         hs_reg;
    logic [HS_W-1:0]         eh;
    logic [RW-1:0]           row_reg;
    logic                    nz_reg;
    logic [RW-1:0]           rcnt_reg;
    logic [ADDRESS_BITS-1:0] pos_reg;
    logic                    pfull_reg;
    logic [ADDRESS_BITS-1:0] hack_reg;
    logic [BW-1:0]           base_reg;
    logic [OFFSET_W-1:0]     offset_reg;
    logic                    eoh_reg;
    logic                    m_valid_reg;
    out_t                    m_data_reg;

    logic                    accept;
    logic                    store;
    logic [ELEMENT_BITS-1:0] elem;
    logic [ELEMENT_BITS-1:0] rdata;
    logic                    out_free;
    logic                    fire;
    logic                    more;
    logic [SW-1:0]           val_sum;
    logic                    val_sat;
    logic                    hack_sat;
    logic [ADDRESS_BITS-1:0] addr_ab;
    logic [AXW-1:0]          addr_ext;
    out_t                    res;

    assign accept   = s_valid && ctrl.take;
    assign elem     = s_data.element_bits[ELEMENT_BITS-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = ctrl.emit && out_free;
    assign store    = accept && ((HS_W + 1)'(row_reg) < (HS_W + 1)'(eh));
    assign more     = ((RW + 1)'(rcnt_reg) + (RW + 1)'(1)) < (RW + 1)'(row_reg);

    // Hack size in force, clamped to 1..HACK_MAX.
    always_comb begin
        if (hs_reg == '0) begin
            eh = HS_W'(1);
        end else if (hs_reg > HS_W'(HACK_MAX)) begin
            eh = HS_W'(HACK_MAX);
        end else begin
            eh = hs_reg;
        end
    end

    // Buffer for the rows of one diagonal group.
    d2h_ram #(
        .WIDTH(ELEMENT_BITS),
        .DEPTH(HACK_MAX)
    ) u_buf (
        .aclk  (aclk),
        .we    (store),
        .waddr (row_reg[RAW-1:0]),
        .wdata (elem),
        .re    (ctrl.rd_en),
        .raddr (rcnt_reg[RAW-1:0]),
        .rdata (rdata)
    );

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hs_reg <= HS_RESET;
        end else if (cfg_valid) begin
            hs_reg <= cfg_data;
        end
    end

    // Group, position and hack counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            nz_reg    <= 1'b0;
            rcnt_reg  <= '0;
            pos_reg   <= '0;
            pfull_reg <= 1'b0;
            hack_reg  <= '0;
            eoh_reg   <= 1'b0;
        end else begin
            if (store) begin
                row_reg <= row_reg + RW'(1);
                if (elem != '0) begin
                    nz_reg <= 1'b1;
                end
            end
            if (accept) begin
                eoh_reg <= s_data.end_of_hack;
            end
            if (ctrl.base_load) begin
                rcnt_reg <= '0;
            end else if (fire && ctrl.kind == KIND_VALUE) begin
                rcnt_reg <= rcnt_reg + RW'(1);
            end
            if (ctrl.group_done) begin
                row_reg <= '0;
                nz_reg  <= 1'b0;
                if (nz_reg) begin
                    if (pos_reg == ADDR_MAX) begin
                        pfull_reg <= 1'b1;
                    end else begin
                        pos_reg <= pos_reg + ADDRESS_BITS'(1);
                    end
                end
            end
            if (fire && ctrl.kind == KIND_HACK && !hack_sat) begin
                hack_reg <= hack_reg + ADDRESS_BITS'(1);
            end
        end
    end

    // Diagonal offset and the row base address of the group.
    always_ff @(posedge aclk) begin
        if (accept) begin
            offset_reg <= s_data.diag_offset;
        end
        if (ctrl.base_load) begin
            base_reg <= BW'(pos_reg) * BW'(eh);
        end
    end

    // Result assembly for the current step.
    always_comb begin
        val_sum  = SW'(base_reg) + SW'(rcnt_reg);
        val_sat  = (val_sum > SW'(ADDR_MAX));
        hack_sat = (hack_reg == ADDR_MAX);
        res      = '0;
        res.kind = ctrl.kind;
        case (ctrl.kind)
            KIND_VALUE: begin
                addr_ab      = val_sat ? ADDR_MAX : val_sum[ADDRESS_BITS-1:0];
                res.data     = DATA_FIELD_W'(rdata);
                res.overflow = pfull_reg || val_sat;
            end
            KIND_DIAG: begin
                addr_ab      = pos_reg;
                res.data     = {{(DATA_FIELD_W - OFFSET_W){offset_reg[OFFSET_W-1]}},
                                offset_reg};
                res.overflow = pfull_reg;
            end
            KIND_HACK: begin
                addr_ab      = hack_sat ? ADDR_MAX : hack_reg + ADDRESS_BITS'(1);
                res.data     = DATA_FIELD_W'((ADDRESS_BITS + 1)'(pos_reg)
                                             + (ADDRESS_BITS + 1)'(pfull_reg));
                res.overflow = pfull_reg || hack_sat;
            end
            default: begin
                addr_ab = '0;
            end
        endcase
        addr_ext    = AXW'(addr_ab);
        res.address = addr_ext[ADDR_FIELD_W-1:0];
        case (ctrl.last_sel)
            LAST_ROWS:   res.last = !eoh_reg && !more;
            LAST_ALWAYS: res.last = 1'b1;
            default:     res.last = 1'b0;
        endcase
    end

    // Output register: loads on an emitting step, empties on a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status for the sequencer.
    assign stat.acc_end  = accept && (s_data.end_of_diagonal || s_data.end_of_hack);
    assign stat.nz       = nz_reg;
    assign stat.more     = more;
    assign stat.eoh      = eoh_reg;
    assign stat.out_free = out_free;

endmodule

>>> rtl/dia_to_hacked_dia_converter.sv
// Top level of the DIA to hacked-DIA converter: sequencer and datapath.
//
//   Channel   Ports                               Moves
//   config    cfg_valid, cfg_ready, cfg_data      hack size register write
//   input     s_valid, s_ready, s_data            one matrix element row item
//   result    m_valid, m_ready, m_data            one value, offset or hack write
//
// An item that does not close a group is taken on the idle step. An item that closes a
// nonzero group runs the group and offset steps, a read and a value step per row, then
// group done and, at a hack end, the hack step; an all-zero group skips offset and rows.
// Each buffered row costs two microcode steps, one for the buffer read port and
// one for the write into the output register. A stalled output register holds the
// sequencer on its emitting step. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module dia_to_hacked_dia_converter
    import d2h_pkg::*;
#(
    parameter int HACK_MAX     = 32,
    parameter int ELEMENT_BITS = 64,
    parameter int ADDRESS_BITS = 24
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [HS_W-1:0] cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_t             s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_t            m_data
);

    ctrl_t ctrl;
    stat_t stat;

    // The register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Input is taken only on the idle step of the microprogram.
    assign s_ready = ctrl.take;

    // Microprogram sequencer.
    d2h_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // Datapath.
    d2h_dp #(
        .HACK_MAX     (HACK_MAX),
        .ELEMENT_BITS (ELEMENT_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the DIA to hacked-DIA converter with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import d2h_pkg::*;

    localparam int HACK_ROWS    = 32;
    localparam longint unsigned ADDR_LIMIT = (64'd1 << 24) - 1;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;

    // Predicts the hacked-DIA writes of each accepted row item and checks the result stream.
    class hack_write_scoreboard;
        logic [HS_W-1:0]  hack_reg = HS_RESET;
        logic [63:0]      rows[HACK_ROWS];
        int unsigned      fill = 0;
        bit               nonzero = 0;
        longint unsigned  position = 0;
        bit               pos_full = 0;
        longint unsigned  hack_idx = 0;
        out_t             pending_writes[$];
        out_t             batch[$];
        int               errors = 0;

        function void set_hack_size(logic [HS_W-1:0] v);
            hack_reg = v;
        endfunction

        function int outstanding();
            return pending_writes.size();
        endfunction

        function void add_write(logic [1:0] kind, longint unsigned addr, logic [63:0] data,
                                bit ovf);
            out_t w;
            w.kind     = kind;
            w.address  = addr[23:0];
            w.data     = data;
            w.overflow = ovf;
            w.last     = 1'b0;
            batch.push_back(w);
        endfunction

        // Work out the writes that one accepted row item causes.
        function void note_item(in_t it);
            int unsigned     eh;
            longint unsigned a;
            bit              ovf;
            logic [63:0]     off_ext;
            out_t            w;
            eh = (hack_reg == 0) ? 1 : ((hack_reg > HACK_ROWS) ? HACK_ROWS : int'(hack_reg));
            batch.delete();

            // Rows beyond the hack size are dropped but their end marks still act.
            if (fill < eh && fill < HACK_ROWS) begin
                rows[fill] = it.element_bits;
                fill++;
                if (it.element_bits != 0) nonzero = 1;
            end
            off_ext = {{48{it.diag_offset[15]}}, it.diag_offset};

            // A closed group with any set bit gets the next compacted position.
            if (it.end_of_diagonal || it.end_of_hack) begin
                if (nonzero) begin
                    add_write(KIND_DIAG, position, off_ext, pos_full);
                    for (int r = 0; r < fill; r++) begin
                        a   = position * eh + r;
                        ovf = pos_full;
                        if (a > ADDR_LIMIT) begin
                            a   = ADDR_LIMIT;
                            ovf = 1;
                        end
                        add_write(KIND_VALUE, a, rows[r], ovf);
                    end
                    if (position >= ADDR_LIMIT) begin
                        position = ADDR_LIMIT;
                        pos_full = 1;
                    end else begin
                        position++;
                    end
                end
                fill    = 0;
                nonzero = 0;
            end

            // The end of a hack writes the cumulative diagonal count.
            if (it.end_of_hack) begin
                a   = hack_idx + 1;
                ovf = pos_full;
                if (a > ADDR_LIMIT) begin
                    a   = ADDR_LIMIT;
                    ovf = 1;
                end
                add_write(KIND_HACK, a, position + (pos_full ? 1 : 0), ovf);
                if (hack_idx < ADDR_LIMIT) hack_idx++;
            end

            if (batch.size() > 0) begin
                w = batch.pop_back();
                w.last = 1'b1;
                batch.push_back(w);
            end
            foreach (batch[i]) pending_writes.push_back(batch[i]);
        endfunction

        function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        endfunction

        // Compare one result transfer with the oldest predicted write.
        function void check_write(out_t got);
            out_t exp_w;
            if (pending_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                return;
            end
            exp_w = pending_writes.pop_front();
            if (got.kind !== exp_w.kind) report("kind", 64'(exp_w.kind), 64'(got.kind));
            if (got.address !== exp_w.address)
                report("address", 64'(exp_w.address), 64'(got.address));
            if (got.data !== exp_w.data) report("data", exp_w.data, got.data);
            if (got.overflow !== exp_w.overflow)
                report("overflow", 64'(exp_w.overflow), 64'(got.overflow));
            if (got.last !== exp_w.last) report("last", 64'(exp_w.last), 64'(got.last));
        endfunction
    endclass

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [HS_W-1:0] cfg_data = '0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    in_t             s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    out_t            m_data;

    hack_write_scoreboard sb = new();
    in_t stim_q[$];
    int  items_taken = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  stall_cycles = 0;

    dia_to_hacked_dia_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Both sides run without gaps for a stretch in the middle of the run.
    function automatic bit steady_stretch();
        return items_taken >= 150 && items_taken < 210;
    endfunction

    // Result side: random stalls plus one long hold-off that fills the block.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_taken >= 90) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= steady_stretch() || ($urandom_range(99) >= 31);
        end
    end

    // Every result transfer is checked against the prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_write(m_data);
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic in_t row_item(logic [63:0] bits, logic [15:0] off, bit eod, bit eoh);
        in_t it;
        it.element_bits    = bits;
        it.diag_offset     = off;
        it.end_of_diagonal = eod;
        it.end_of_hack     = eoh;
        return it;
    endfunction

    function automatic logic [63:0] element_value(int mode);
        case (mode)
            0: return '0;
            1: return ($urandom_range(3) == 0) ? (64'd1 << $urandom_range(63)) : 64'd0;
            2: return {$urandom, $urandom};
            default: begin
                case ($urandom_range(2))
                    0: return '1;
                    1: return 64'h8000_0000_0000_0000;
                    default: return 64'd1;
                endcase
            end
        endcase
    endfunction

    // Mostly well-formed hacks with random content, the rest loose rows with random marks.
    task automatic queue_random_traffic(input int eh, input int target);
        int start;
        int ndiag;
        int nrows;
        int mode;
        logic [15:0] off;
        start = stim_q.size();
        while (stim_q.size() - start < target) begin
            if ($urandom_range(99) < 80) begin
                ndiag = $urandom_range(1, 4);
                for (int d = 0; d < ndiag; d++) begin
                    off   = 16'($urandom);
                    mode  = $urandom_range(0, 3);
                    nrows = eh;
                    if ($urandom_range(9) == 0) nrows = $urandom_range(1, eh + 2);
                    for (int r = 0; r < nrows; r++) begin
                        stim_q.push_back(row_item(element_value(mode), off, r == nrows - 1,
                                                  (r == nrows - 1) && (d == ndiag - 1)));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    stim_q.push_back(row_item(element_value($urandom_range(0, 3)),
                                              16'($urandom),
                                              $urandom_range(99) < 25,
                                              $urandom_range(99) < 10));
                end
            end
        end
    endtask

    // Offer one row item and wait for its transfer.
    task automatic offer_item(input in_t it);
        while (!steady_stretch() && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(it);
        items_taken++;
    endtask

    task automatic stream_queue();
        while (stim_q.size() != 0) offer_item(stim_q.pop_front());
        s_valid <= 1'b0;
    endtask

    // Wait until every predicted write has arrived and the sequencer has settled.
    task automatic drain();
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_hack_size(input logic [HS_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_hack_size(v);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [HS_W-1:0] sizes[9];
        sizes = '{6'd1, 6'd3, 6'd5, 6'd8, 6'd2, 6'd0, 6'd63, 6'd4, 6'd1};
        sizes[8] = HS_W'($urandom_range(1, 12));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset hack size: extremes, end of hack without end of diagonal, all-zero groups,
        // and a group left open across a size change.
        stim_q.push_back(row_item('1, 16'h8000, 0, 0));
        stim_q.push_back(row_item('0, 16'h7FFF, 0, 1));
        stim_q.push_back(row_item('0, 16'h0005, 1, 0));
        stim_q.push_back(row_item('0, 16'hFFFF, 1, 1));
        stim_q.push_back(row_item(64'h8000_0000_0000_0000, 16'h0000, 1, 0));
        repeat (3) stim_q.push_back(row_item({$urandom, $urandom}, 16'h0064, 0, 0));
        stream_queue();
        drain();

        // Shrinking the hack size mid-group flushes every buffered row; extra rows drop.
        write_hack_size(6'd2);
        stim_q.push_back(row_item('1, 16'h0064, 0, 0));
        stim_q.push_back(row_item({$urandom, $urandom}, 16'h0064, 1, 0));
        stim_q.push_back(row_item('0, 16'hFFF9, 0, 0));
        stim_q.push_back(row_item('0, 16'hFFF9, 0, 0));
        stim_q.push_back(row_item('1, 16'hFFF9, 1, 0));
        stream_queue();
        drain();

        // A size of zero acts as one row per hack.
        write_hack_size(6'd0);
        stim_q.push_back(row_item(64'd5, 16'h0001, 1, 0));
        stim_q.push_back(row_item('0, 16'h0002, 0, 1));
        stim_q.push_back(row_item(64'd1, 16'h0003, 0, 0));
        stim_q.push_back(row_item('1, 16'h0003, 1, 1));
        stream_queue();
        drain();

        // Sizes above the maximum clamp to it.
        write_hack_size(6'd63);
        stim_q.push_back(row_item(64'h5555_5555_5555_5555, 16'h5555, 1, 0));
        stim_q.push_back(row_item(64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, 0, 1));
        stream_queue();
        drain();
        write_hack_size(6'd33);
        stim_q.push_back(row_item(64'd1, 16'h7FFF, 1, 1));
        stream_queue();

        // Random traffic over a range of hack sizes.
        foreach (sizes[i]) begin
            drain();
            write_hack_size(sizes[i]);
            queue_random_traffic((sizes[i] == 0) ? 1 : ((sizes[i] > HACK_ROWS) ? HACK_ROWS
                                                        : int'(sizes[i])), 18);
            stream_queue();
        end

        drain();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
